// ===== src/wsfr_pkg.sv =====
// Package for the WebSocket frame receiver: parse phase codes, frame status
// codes, the result beat type and the push bundle between parser and queue.
// No dependencies.
package wsfr_pkg;

    // Depth of the result queue; at least two so one byte's results always fit.
    localparam int WSFR_QUEUE_DEPTH = 4;

    // Parse phases.
    localparam logic [3:0] PH_HDR0    = 4'd0;
    localparam logic [3:0] PH_HDR1    = 4'd1;
    localparam logic [3:0] PH_LEN_HI  = 4'd2;
    localparam logic [3:0] PH_LEN_LO  = 4'd3;
    localparam logic [3:0] PH_KEY     = 4'd4;
    localparam logic [3:0] PH_PAYLOAD = 4'd5;
    localparam logic [3:0] PH_SKIP    = 4'd6;

    // Frame status codes.
    localparam logic [3:0] ST_TEXT_DONE  = 4'd0;
    localparam logic [3:0] ST_CLOSE      = 4'd1;
    localparam logic [3:0] ST_FRAGMENT   = 4'd2;
    localparam logic [3:0] ST_BINARY     = 4'd3;
    localparam logic [3:0] ST_PING       = 4'd4;
    localparam logic [3:0] ST_PONG       = 4'd5;
    localparam logic [3:0] ST_OTHER      = 4'd6;
    localparam logic [3:0] ST_LONG       = 4'd7;
    localparam logic [3:0] ST_INCOMPLETE = 4'd8;
    localparam logic [3:0] ST_RSV        = 4'd9;
    localparam logic [3:0] ST_UNMASKED   = 4'd10;
    localparam logic [3:0] ST_CONTINUE   = 4'd11;

    // Header field codes.
    localparam logic [7:0] HDR_FIN_MASK  = 8'h80;
    localparam logic [7:0] HDR_RSV_MASK  = 8'h70;
    localparam logic [7:0] HDR_MASK_BIT  = 8'h80;
    localparam logic [3:0] OP_CONTINUE   = 4'h0;
    localparam logic [3:0] OP_TEXT       = 4'h1;
    localparam logic [3:0] OP_BINARY     = 4'h2;
    localparam logic [3:0] OP_CLOSE      = 4'h8;
    localparam logic [3:0] OP_PING       = 4'h9;
    localparam logic [3:0] OP_PONG       = 4'hA;
    localparam logic [6:0] LEN_EXT16     = 7'd126;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_status;
        logic       last_of_run;
    } t_result;

    // Results of one accepted byte: count is 0, 1 or 2; first goes out first.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== src/wsfr_if.sv =====
// Channel interfaces of the WebSocket frame receiver: input byte beats and
// result beats, valid/ready handshake. No dependencies.
interface wsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface wsfr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_status;
    logic       last_of_run;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_status, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_status, input last_of_run, output ready);
endinterface

// ===== src/wsfr_parse.sv =====
// Frame header parser and payload unmasker: holds the parse state and turns
// each accepted byte into zero, one or two results. Depends on wsfr_pkg.
module wsfr_parse
    import wsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_chunk_end,
    output t_push      o_push
);

    logic [3:0]  r_phase,   n_phase;
    logic [7:0]  r_hdr0,    n_hdr0;
    logic [3:0]  r_verdict, n_verdict;
    logic [7:0]  r_len_hi,  n_len_hi;
    logic [15:0] r_remain,  n_remain;
    logic [31:0] r_key,     n_key;
    logic [1:0]  r_key_pos, n_key_pos;

    logic        w_payload;
    logic [7:0]  w_unmasked;
    logic [3:0]  w_opcode;
    logic [6:0]  w_len7;
    t_result     w_pay_res;
    t_result     w_st_res;

    assign w_opcode   = r_hdr0[3:0];
    assign w_len7     = i_rx_byte[6:0];
    assign w_unmasked = i_rx_byte ^ r_key[{r_key_pos, 3'b000} +: 8];

    always_comb begin
        n_phase   = r_phase;
        n_hdr0    = r_hdr0;
        n_verdict = r_verdict;
        n_len_hi  = r_len_hi;
        n_remain  = r_remain;
        n_key     = r_key;
        n_key_pos = r_key_pos;
        w_payload = 1'b0;
        unique case (r_phase)
            PH_HDR0: begin
                n_hdr0    = i_rx_byte;
                n_verdict = ST_INCOMPLETE;
                n_phase   = PH_HDR1;
            end
            PH_HDR1: begin
                n_phase = PH_SKIP;
                priority if ((r_hdr0 & HDR_FIN_MASK) != HDR_FIN_MASK) begin
                    n_verdict = ST_FRAGMENT;
                end else if ((r_hdr0 & HDR_RSV_MASK) != 8'h00) begin
                    n_verdict = ST_RSV;
                end else if ((i_rx_byte & HDR_MASK_BIT) != HDR_MASK_BIT) begin
                    n_verdict = ST_UNMASKED;
                end else if (w_opcode == OP_CONTINUE) begin
                    n_verdict = ST_CONTINUE;
                end else if (w_opcode == OP_TEXT) begin
                    n_verdict = ST_INCOMPLETE;
                    priority if (w_len7 < LEN_EXT16) begin
                        n_remain  = {9'd0, w_len7};
                        n_key_pos = 2'd0;
                        n_phase   = PH_KEY;
                    end else if (w_len7 == LEN_EXT16) begin
                        n_phase = PH_LEN_HI;
                    end else begin
                        n_verdict = ST_LONG;
                    end
                end else if (w_opcode == OP_BINARY) begin
                    n_verdict = ST_BINARY;
                end else if (w_opcode == OP_CLOSE) begin
                    n_verdict = ST_CLOSE;
                end else if (w_opcode == OP_PING) begin
                    n_verdict = ST_PING;
                end else if (w_opcode == OP_PONG) begin
                    n_verdict = ST_PONG;
                end else begin
                    n_verdict = ST_OTHER;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_rx_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_remain  = {r_len_hi, i_rx_byte};
                n_key_pos = 2'd0;
                n_phase   = PH_KEY;
            end
            PH_KEY: begin
                n_key[{r_key_pos, 3'b000} +: 8] = i_rx_byte;
                n_key_pos = r_key_pos + 2'd1;
                if (r_key_pos == 2'd3) begin
                    if (r_remain == 16'd0) begin
                        n_verdict = ST_TEXT_DONE;
                        n_phase   = PH_SKIP;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                w_payload = 1'b1;
                n_key_pos = r_key_pos + 2'd1;
                n_remain  = r_remain - 16'd1;
                if (r_remain == 16'd1) begin
                    n_verdict = ST_TEXT_DONE;
                    n_phase   = PH_SKIP;
                end
            end
            default: begin
                // skip until chunk end
            end
        endcase
        if (i_chunk_end) begin
            n_phase = PH_HDR0;
        end
    end

    always_comb begin
        w_pay_res.result_kind  = KIND_PAYLOAD;
        w_pay_res.payload_byte = w_unmasked;
        w_pay_res.frame_status = ST_TEXT_DONE;
        w_pay_res.last_of_run  = 1'b0;
        w_st_res.result_kind   = KIND_STATUS;
        w_st_res.payload_byte  = 8'h00;
        w_st_res.frame_status  = n_verdict;
        w_st_res.last_of_run   = 1'b1;
        o_push.first  = w_payload ? w_pay_res : w_st_res;
        o_push.second = w_st_res;
        o_push.count  = i_accept ? ({1'b0, w_payload} + {1'b0, i_chunk_end}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_hdr0    <= 8'h00;
            r_verdict <= ST_TEXT_DONE;
            r_len_hi  <= 8'h00;
            r_remain  <= 16'd0;
            r_key     <= 32'd0;
            r_key_pos <= 2'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr0    <= n_hdr0;
            r_verdict <= n_verdict;
            r_len_hi  <= n_len_hi;
            r_remain  <= n_remain;
            r_key     <= n_key;
            r_key_pos <= n_key_pos;
        end
    end

endmodule

// ===== src/wsfr_queue.sv =====
// Result queue: takes up to two result beats per cycle, gives one per cycle
// when popped. Depends on wsfr_pkg.
module wsfr_queue
    import wsfr_pkg::*;
#(
    parameter int P_DEPTH = WSFR_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_result         r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic [PW-1:0]   w_wr_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(P_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign w_wr_next = ptr_inc(r_wr_ptr);
    assign o_room    = r_count <= CW'(P_DEPTH - 2);
    assign o_valid   = r_count != '0;
    assign o_head    = r_mem[r_rd_ptr];

    always_comb begin
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        unique case (i_push.count)
            2'd1:    n_wr_ptr = w_wr_next;
            2'd2:    n_wr_ptr = ptr_inc(w_wr_next);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + CW'(i_push.count) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== src/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver: one input byte beat per cycle while
// the queue has room for two results; result beats are registered in the queue.
// Throughput is one byte per cycle; with a ready sink the output gives one beat
// per cycle, so only a payload byte ending its chunk (two results) adds an entry.
// Synchronous active-low reset returns the parser to the first header byte and
// empties the result queue. Depends on wsfr_pkg, wsfr_if, wsfr_parse, wsfr_queue.
module websocket_frame_receiver
    import wsfr_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = WSFR_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfr_in_if.sink     i_rx,
    wsfr_out_if.source  o_res
);

    logic    w_accept;
    logic    w_pop;
    logic    w_room;
    t_push   w_push;
    t_result w_head;

    // Take a byte only when the queue can hold both results it may cause.
    assign i_rx.ready = w_room;
    assign w_accept   = i_rx.valid && w_room;
    assign w_pop      = o_res.valid && o_res.ready;

    // Header checks, length and key capture, and payload unmasking.
    wsfr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_chunk_end (i_rx.chunk_end),
        .o_push      (w_push)
    );

    // Result queue: decouples the input from a stalled sink.
    wsfr_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (o_res.valid),
        .o_head  (w_head)
    );

    assign o_res.result_kind  = w_head.result_kind;
    assign o_res.payload_byte = w_head.payload_byte;
    assign o_res.frame_status = w_head.frame_status;
    assign o_res.last_of_run  = w_head.last_of_run;

    // A queue without room for two results always has something to offer.
    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> o_res.valid)
        else $error("input stalled with empty result queue");

    // A payload beat never ends the run and carries no status.
    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.result_kind == KIND_PAYLOAD)
        |-> (o_res.frame_status == ST_TEXT_DONE) && !o_res.last_of_run)
        else $error("payload beat with status bits set");

    // A status beat ends the run and carries a zero byte.
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.result_kind == KIND_STATUS)
        |-> o_res.last_of_run && (o_res.payload_byte == 8'h00))
        else $error("status beat malformed");

endmodule
